FILE: hdl/ptb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg - shared types and helpers for the pose transform blend pipeline
// Lane formats, pipeline token, packed item layouts and small lane functions.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int LW      = 16;          // one packed lane
  localparam int QL      = 4;           // quaternion lanes x,y,z,w
  localparam int VL      = 3;           // vector lanes x,y,z
  localparam int QW      = QL * LW;     // packed quaternion
  localparam int VW      = VL * LW;     // packed vector
  localparam int IN_TDW  = 496;
  localparam int OUT_TDW = 160;

  localparam int Q_ONE   = 16384;       // 1.0 in Q2.14
  localparam int W_ONE   = 32768;       // 1.0 in Q1.15

  // normaliser widths
  localparam int MW       = 20;               // signed lane into the normaliser
  localparam int MAGW     = MW - 1;           // lane magnitude
  localparam int SQW      = 2 * MAGW;         // squared magnitude
  localparam int NW       = SQW + 2;          // sum of four squares
  localparam int FRACW    = 20;               // radicand scaling
  localparam int RADW     = NW + FRACW;       // radicand
  localparam int SQ_STEPS = RADW / 2;         // one root bit per stage
  localparam int RTW      = RADW / 2;         // root width
  localparam int SCLW     = 24;               // dividend scaling
  localparam int QTW      = 15;               // quotient never exceeds 1.0
  localparam int DVW      = MAGW + SCLW + 2;  // dividend / remainder
  localparam int DV_STEPS = QTW;

  typedef logic signed [LW-1:0] l16_t;
  typedef logic signed [LW:0]   l17_t;
  typedef logic signed [MW-1:0] l20_t;
  typedef l16_t q16_t [QL];
  typedef l17_t q17_t [QL];
  typedef l20_t q20_t [QL];

  typedef struct packed {
    logic [LW-1:0] blend_weight;
    logic [VW-1:0] bind_scale;
    logic [QW-1:0] bind_rotation;
    logic [VW-1:0] bind_translation;
    logic [VW-1:0] sample_scale;
    logic [QW-1:0] sample_rotation;
    logic [VW-1:0] sample_translation;
    logic [VW-1:0] base_scale;
    logic [QW-1:0] base_rotation;
    logic [VW-1:0] base_translation;
  } in_data_t;

  typedef struct packed {
    logic [VW-1:0] out_scale;
    logic [QW-1:0] out_rotation;
    logic [VW-1:0] out_translation;
  } out_data_t;

  // everything an item carries alongside the rotation arithmetic
  typedef struct packed {
    logic          additive;
    logic [LW-1:0] weight;
    logic [QW-1:0] base_rot;
    logic [QW-1:0] samp_rot;
    logic [VW-1:0] trans;
    logic [VW-1:0] scale;
    logic [QW-1:0] rot_ovr;
  } side_t;

  typedef struct packed {
    logic  vld;
    side_t side;
  } pl_t;

  function automatic l16_t lane16(input logic [QW-1:0] v, input int i);
    return l16_t'(v[LW*i +: LW]);
  endfunction

  function automatic logic [QW-1:0] pack_q16(input q16_t q);
    logic [QW-1:0] r;
    r = '0;
    for (int i = 0; i < QL; i++) r[LW*i +: LW] = q[i];
    return r;
  endfunction

  function automatic l16_t sat16(input l20_t v);
    if (v > 32767) return l16_t'(16'h7FFF);
    if (v < -32768) return l16_t'(16'h8000);
    return v[LW-1:0];
  endfunction

endpackage

FILE: hdl/ptb_vblend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_vblend - input stage and vector blend
// Clamps the weight, blends translation and scale lanes in two stages and
// sets up the operands of sample * conj(bind).
// ----------------------------------------------------------------------------
module ptb_vblend (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        acc_i,
  input  logic                        op_i,
  input  logic [ptb_pkg::IN_TDW-1:0]  data_i,
  output ptb_pkg::pl_t                tok_o,
  output ptb_pkg::q17_t               qa_o,
  output ptb_pkg::q17_t               qb_o
);
  import ptb_pkg::*;

  localparam int NL = 2 * VL;

  in_data_t            d;
  logic [LW-1:0]       w;
  l16_t                to_l [NL];
  l16_t                from_l [NL];
  l16_t                base_l [NL];
  logic signed [LW:0]  diff [NL];

  pl_t                 tok1_r;
  logic signed [33:0]  prod1_r [NL];
  l16_t                base1_r [NL];
  q17_t                qa1_r, qb1_r;

  pl_t                 tok2_r;
  pl_t                 tok2_nxt;
  q17_t                qa2_r, qb2_r;
  logic signed [34:0]  acc [NL];
  logic signed [34:0]  sh [NL];
  l16_t                res [NL];

  assign d = in_data_t'(data_i);
  assign w = (d.blend_weight > LW'(W_ONE)) ? LW'(W_ONE) : d.blend_weight;

  always_comb begin
    for (int i = 0; i < VL; i++) begin
      to_l[i]      = lane16(QW'(d.sample_translation), i);
      to_l[i+VL]   = lane16(QW'(d.sample_scale), i);
      base_l[i]    = lane16(QW'(d.base_translation), i);
      base_l[i+VL] = lane16(QW'(d.base_scale), i);
      from_l[i]    = op_i ? lane16(QW'(d.bind_translation), i) : base_l[i];
      from_l[i+VL] = op_i ? lane16(QW'(d.bind_scale), i) : base_l[i+VL];
    end
    for (int i = 0; i < NL; i++) diff[i] = to_l[i] - from_l[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r.vld <= 1'b0;
    end else if (en) begin
      tok1_r.vld            <= acc_i;
      tok1_r.side.additive  <= op_i;
      tok1_r.side.weight    <= w;
      tok1_r.side.base_rot  <= d.base_rotation;
      tok1_r.side.samp_rot  <= d.sample_rotation;
      tok1_r.side.trans     <= '0;
      tok1_r.side.scale     <= '0;
      tok1_r.side.rot_ovr   <= '0;
      for (int i = 0; i < NL; i++) begin
        prod1_r[i] <= diff[i] * $signed({1'b0, w});
        base1_r[i] <= base_l[i];
      end
      for (int i = 0; i < QL; i++) begin
        qa1_r[i] <= l17_t'(lane16(d.sample_rotation, i));
        // conjugate of the bind rotation: negate x, y, z
        qb1_r[i] <= (i < QL - 1) ? -l17_t'(lane16(d.bind_rotation, i))
                                 : l17_t'(lane16(d.bind_rotation, i));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      acc[i] = prod1_r[i] + 35'sd16384;
      sh[i]  = acc[i] >>> 15;
      res[i] = sat16(MW'(sh[i] + 35'(base1_r[i])));
    end
  end

  always_comb begin
    tok2_nxt = tok1_r;
    for (int i = 0; i < VL; i++) begin
      tok2_nxt.side.trans[LW*i +: LW] = res[i];
      tok2_nxt.side.scale[LW*i +: LW] = res[i+VL];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok2_r.vld <= 1'b0;
    end else if (en) begin
      tok2_r <= tok2_nxt;
      qa2_r  <= qa1_r;
      qb2_r  <= qb1_r;
    end
  end

  assign tok_o = tok2_r;
  assign qa_o  = qa2_r;
  assign qb_o  = qb2_r;

endmodule

FILE: hdl/ptb_qmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_qmul - quaternion product
// Sixteen lane products in one stage, signed sums rounded to Q2.14 in the next.
// ----------------------------------------------------------------------------
module ptb_qmul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  ptb_pkg::pl_t   tok_i,
  input  ptb_pkg::q17_t  a_i,
  input  ptb_pkg::q17_t  b_i,
  output ptb_pkg::pl_t   tok_o,
  output ptb_pkg::q20_t  q_o
);
  import ptb_pkg::*;

  pl_t                tok1_r;
  logic signed [33:0] p_r [QL][QL];   // p_r[i][j] = a[i] * b[j]
  logic signed [35:0] acc [QL];
  logic signed [35:0] rnd [QL];
  pl_t                tok2_r;
  q20_t               q2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r.vld <= 1'b0;
    end else if (en) begin
      tok1_r <= tok_i;
      for (int i = 0; i < QL; i++) begin
        for (int j = 0; j < QL; j++) p_r[i][j] <= a_i[i] * b_i[j];
      end
    end
  end

  always_comb begin
    acc[0] = p_r[3][0] + p_r[0][3] + p_r[1][2] - p_r[2][1];
    acc[1] = p_r[3][1] - p_r[0][2] + p_r[1][3] + p_r[2][0];
    acc[2] = p_r[3][2] + p_r[0][1] - p_r[1][0] + p_r[2][3];
    acc[3] = p_r[3][3] - p_r[0][0] - p_r[1][1] - p_r[2][2];
    for (int i = 0; i < QL; i++) rnd[i] = (acc[i] + 36'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok2_r.vld <= 1'b0;
    end else if (en) begin
      tok2_r <= tok1_r;
      for (int i = 0; i < QL; i++) q2_r[i] <= MW'(rnd[i]);
    end
  end

  assign tok_o = tok2_r;
  assign q_o   = q2_r;

endmodule

FILE: hdl/ptb_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_norm - pipelined quaternion normaliser
// Sum of squares, one root bit per stage, then one quotient bit per stage for
// all four lanes. A zero-length quaternion gives the identity.
// ----------------------------------------------------------------------------
module ptb_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  ptb_pkg::pl_t   tok_i,
  input  ptb_pkg::q20_t  v_i,
  output ptb_pkg::pl_t   tok_o,
  output ptb_pkg::q16_t  q_o
);
  import ptb_pkg::*;

  logic [MW-1:0]   abs_v [QL];

  // squares
  pl_t             tok_a_r;
  logic [QL-1:0]   neg_a_r;
  logic [MAGW-1:0] mag_a_r [QL];
  logic [SQW-1:0]  sq_a_r [QL];
  logic [NW-1:0]   n_sum;

  // root stages
  pl_t             tok_s [SQ_STEPS+1];
  logic [QL-1:0]   neg_s [SQ_STEPS+1];
  logic            zero_s [SQ_STEPS+1];
  logic [MAGW-1:0] mag_s [SQ_STEPS+1][QL];
  logic [RADW-1:0] rad_s [SQ_STEPS+1];
  logic [RADW-1:0] root_s [SQ_STEPS+1];

  // divide stages
  pl_t             tok_d [DV_STEPS+1];
  logic [QL-1:0]   neg_d [DV_STEPS+1];
  logic            zero_d [DV_STEPS+1];
  logic [RTW-1:0]  s_d [DV_STEPS+1];
  logic [DVW-1:0]  rem_d [DV_STEPS+1][QL];
  logic [QTW-1:0]  quo_d [DV_STEPS+1][QL];

  pl_t             tok_o_r;
  q16_t            q_o_r;

  always_comb begin
    for (int i = 0; i < QL; i++) abs_v[i] = v_i[i][MW-1] ? MW'(-v_i[i]) : MW'(v_i[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_a_r.vld <= 1'b0;
    end else if (en) begin
      tok_a_r <= tok_i;
      for (int i = 0; i < QL; i++) begin
        neg_a_r[i] <= v_i[i][MW-1];
        mag_a_r[i] <= abs_v[i][MAGW-1:0];
        sq_a_r[i]  <= abs_v[i][MAGW-1:0] * abs_v[i][MAGW-1:0];
      end
    end
  end

  always_comb begin
    n_sum = '0;
    for (int i = 0; i < QL; i++) n_sum = n_sum + NW'(sq_a_r[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_s[0].vld <= 1'b0;
    end else if (en) begin
      tok_s[0]  <= tok_a_r;
      neg_s[0]  <= neg_a_r;
      zero_s[0] <= (n_sum == '0);
      mag_s[0]  <= mag_a_r;
      rad_s[0]  <= {n_sum, FRACW'(0)};
      root_s[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_root
    localparam logic [RADW-1:0] BIT = RADW'(1) << (RADW - 2 - 2 * k);
    logic [RADW-1:0] trial;
    logic            take;

    assign trial = root_s[k] + BIT;
    assign take  = rad_s[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tok_s[k+1].vld <= 1'b0;
      end else if (en) begin
        tok_s[k+1]  <= tok_s[k];
        neg_s[k+1]  <= neg_s[k];
        zero_s[k+1] <= zero_s[k];
        mag_s[k+1]  <= mag_s[k];
        rad_s[k+1]  <= take ? rad_s[k] - trial : rad_s[k];
        root_s[k+1] <= take ? (root_s[k] >> 1) + BIT : root_s[k] >> 1;
      end
    end
  end

  // dividend: |v| scaled up, plus half the root for rounding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_d[0].vld <= 1'b0;
    end else if (en) begin
      tok_d[0]  <= tok_s[SQ_STEPS];
      neg_d[0]  <= neg_s[SQ_STEPS];
      zero_d[0] <= zero_s[SQ_STEPS];
      s_d[0]    <= root_s[SQ_STEPS][RTW-1:0];
      for (int i = 0; i < QL; i++) begin
        rem_d[0][i] <= DVW'({mag_s[SQ_STEPS][i], SCLW'(0)})
                     + DVW'(root_s[SQ_STEPS][RTW-1:1]);
        quo_d[0][i] <= '0;
      end
    end
  end

  for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
    localparam int SH = DV_STEPS - 1 - k;
    logic [DVW-1:0] dsh;
    logic [QL-1:0]  take;

    assign dsh = DVW'(s_d[k]) << SH;
    always_comb begin
      for (int i = 0; i < QL; i++) take[i] = rem_d[k][i] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tok_d[k+1].vld <= 1'b0;
      end else if (en) begin
        tok_d[k+1]  <= tok_d[k];
        neg_d[k+1]  <= neg_d[k];
        zero_d[k+1] <= zero_d[k];
        s_d[k+1]    <= s_d[k];
        for (int i = 0; i < QL; i++) begin
          rem_d[k+1][i] <= take[i] ? rem_d[k][i] - dsh : rem_d[k][i];
          quo_d[k+1][i] <= quo_d[k][i] | (take[i] ? QTW'(1) << SH : QTW'(0));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_o_r.vld <= 1'b0;
    end else if (en) begin
      tok_o_r <= tok_d[DV_STEPS];
      for (int i = 0; i < QL; i++) begin
        if (zero_d[DV_STEPS]) begin
          q_o_r[i] <= (i == QL - 1) ? l16_t'(Q_ONE) : l16_t'(0);
        end else if (neg_d[DV_STEPS][i]) begin
          q_o_r[i] <= -l16_t'({1'b0, quo_d[DV_STEPS][i]});
        end else begin
          q_o_r[i] <= l16_t'({1'b0, quo_d[DV_STEPS][i]});
        end
      end
    end
  end

  assign tok_o = tok_o_r;
  assign q_o   = q_o_r;

endmodule

FILE: hdl/ptb_nlerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_nlerp - quaternion lerp ahead of normalisation
// Dot product, hemisphere flip of the target, weighted lane mix.
// Override: base toward sample. Additive: identity toward the delta.
// ----------------------------------------------------------------------------
module ptb_nlerp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  ptb_pkg::pl_t   tok_i,
  input  ptb_pkg::q16_t  r_i,
  output ptb_pkg::pl_t   tok_o,
  output ptb_pkg::q20_t  t_o
);
  import ptb_pkg::*;

  l16_t               a0 [QL];
  l16_t               r0 [QL];

  pl_t                tok1_r;
  l16_t               a1_r [QL];
  l16_t               r1_r [QL];
  logic signed [31:0] dp1_r [QL];

  logic signed [33:0] dot;
  l17_t               bsel [QL];

  pl_t                tok2_r;
  l16_t               a2_r [QL];
  logic signed [17:0] d2_r [QL];

  pl_t                tok3_r;
  l16_t               a3_r [QL];
  logic signed [34:0] pr3_r [QL];

  logic signed [35:0] acc [QL];
  logic signed [35:0] sh [QL];

  pl_t                tok4_r;
  q20_t               t4_r;

  always_comb begin
    for (int i = 0; i < QL; i++) begin
      if (tok_i.side.additive) begin
        a0[i] = (i == QL - 1) ? l16_t'(Q_ONE) : l16_t'(0);
        r0[i] = r_i[i];
      end else begin
        a0[i] = lane16(tok_i.side.base_rot, i);
        r0[i] = lane16(tok_i.side.samp_rot, i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r.vld <= 1'b0;
    end else if (en) begin
      tok1_r <= tok_i;
      for (int i = 0; i < QL; i++) begin
        a1_r[i]  <= a0[i];
        r1_r[i]  <= r0[i];
        dp1_r[i] <= a0[i] * r0[i];
      end
    end
  end

  // take the short way round: flip the target on a strictly negative dot
  always_comb begin
    dot = '0;
    for (int i = 0; i < QL; i++) dot = dot + 34'(dp1_r[i]);
    for (int i = 0; i < QL; i++) bsel[i] = dot[33] ? -l17_t'(r1_r[i]) : l17_t'(r1_r[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok2_r.vld <= 1'b0;
    end else if (en) begin
      tok2_r <= tok1_r;
      for (int i = 0; i < QL; i++) begin
        a2_r[i] <= a1_r[i];
        d2_r[i] <= bsel[i] - a1_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok3_r.vld <= 1'b0;
    end else if (en) begin
      tok3_r <= tok2_r;
      for (int i = 0; i < QL; i++) begin
        a3_r[i]  <= a2_r[i];
        pr3_r[i] <= d2_r[i] * $signed({1'b0, tok2_r.side.weight});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < QL; i++) begin
      acc[i] = pr3_r[i] + 36'sd16384;
      sh[i]  = acc[i] >>> 15;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok4_r.vld <= 1'b0;
    end else if (en) begin
      tok4_r <= tok3_r;
      for (int i = 0; i < QL; i++) t4_r[i] <= MW'(sh[i] + 36'(a3_r[i]));
    end
  end

  assign tok_o = tok4_r;
  assign t_o   = t4_r;

endmodule

FILE: hdl/pose_transform_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_transform_blend - bone transform blend pipeline
// Override blend or additive layer of one bone transform per transfer.
// ----------------------------------------------------------------------------
// Input: one bone per in_ transfer; in_tuser selects override (0) or
// additive (1), in_tdata carries base, sample and bind transforms plus the
// weight. Output: one blended transform per out_ transfer, in input order.
// Throughput is one item per clock while the skid register is empty. The
// rotation path runs through a quaternion product, the first of three
// normalisers (each a root bit per stage, then a quotient bit per stage),
// the lerp, the second normaliser, a second product and the third normaliser.
// Every item takes the full path; override items pick their rotation after
// the second normaliser.
// Reset clears all valid bits; the pipeline starts empty with in_tready high.
// If the receiver stalls, one more result drops into a skid register, then
// the whole pipeline holds and in_tready falls until the skid register empties.
// ----------------------------------------------------------------------------
module pose_transform_blend (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // base_translation, base_rotation, base_scale, sample_translation,
  // sample_rotation, sample_scale, bind_translation, bind_rotation,
  // bind_scale, blend_weight
  input  logic [ptb_pkg::IN_TDW-1:0]   in_tdata,
  input  logic                         in_tuser,   // operation
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // out_translation, out_rotation, out_scale
  output logic [ptb_pkg::OUT_TDW-1:0]  out_tdata
);
  import ptb_pkg::*;

  logic      en;
  logic      acc_in;

  pl_t       tok_vb, tok_m1, tok_n1, tok_nl, tok_n2, tok_m2i, tok_m2, tok_n3;
  q17_t      qa1, qb1, qa2, qb2;
  q20_t      q_m1, q_nl, q_m2;
  q16_t      q_n1, q_n2, q_n3;

  out_data_t fin_dat;
  logic      push, pop;
  logic      out_vld_r, skid_vld_r;
  out_data_t out_dat_r, skid_dat_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;
  assign acc_in    = in_tvalid && in_tready;

  ptb_vblend u_vblend (
    .clk, .rst_n, .en,
    .acc_i (acc_in),
    .op_i  (in_tuser),
    .data_i(in_tdata),
    .tok_o (tok_vb),
    .qa_o  (qa1),
    .qb_o  (qb1)
  );

  // delta = sample * conj(bind)
  ptb_qmul u_qmul_d (
    .clk, .rst_n, .en,
    .tok_i(tok_vb), .a_i(qa1), .b_i(qb1),
    .tok_o(tok_m1), .q_o(q_m1)
  );

  ptb_norm u_norm_d (
    .clk, .rst_n, .en,
    .tok_i(tok_m1), .v_i(q_m1),
    .tok_o(tok_n1), .q_o(q_n1)
  );

  ptb_nlerp u_nlerp (
    .clk, .rst_n, .en,
    .tok_i(tok_n1), .r_i(q_n1),
    .tok_o(tok_nl), .t_o(q_nl)
  );

  ptb_norm u_norm_l (
    .clk, .rst_n, .en,
    .tok_i(tok_nl), .v_i(q_nl),
    .tok_o(tok_n2), .q_o(q_n2)
  );

  // the override result is final here; additive goes on to base * blend
  always_comb begin
    tok_m2i = tok_n2;
    tok_m2i.side.rot_ovr = pack_q16(q_n2);
    for (int i = 0; i < QL; i++) begin
      qa2[i] = l17_t'(lane16(tok_n2.side.base_rot, i));
      qb2[i] = l17_t'(q_n2[i]);
    end
  end

  ptb_qmul u_qmul_b (
    .clk, .rst_n, .en,
    .tok_i(tok_m2i), .a_i(qa2), .b_i(qb2),
    .tok_o(tok_m2), .q_o(q_m2)
  );

  ptb_norm u_norm_b (
    .clk, .rst_n, .en,
    .tok_i(tok_m2), .v_i(q_m2),
    .tok_o(tok_n3), .q_o(q_n3)
  );

  always_comb begin
    fin_dat.out_translation = tok_n3.side.trans;
    fin_dat.out_scale       = tok_n3.side.scale;
    fin_dat.out_rotation    = tok_n3.side.additive ? pack_q16(q_n3) : tok_n3.side.rot_ovr;
  end

  assign push = en && tok_n3.vld;
  assign pop  = out_vld_r && out_tready;

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        out_dat_r  <= skid_dat_r;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || pop) begin
      out_vld_r <= push;
      if (push) begin
        out_dat_r <= fin_dat;
      end
    end else if (push) begin
      skid_dat_r <= fin_dat;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register holds a result while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid register filled without a stalled output");

  a_rot_w_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[111:96]) <= Q_ONE &&
                    $signed(out_tdata[111:96]) >= -Q_ONE))
    else $error("rotation w lane outside the unit range");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the pose transform blend pipeline
// Streams override and additive bone transforms through the block, predicts
// every blended transform in fixed point and compares it lane field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import ptb_pkg::*;

  typedef longint quat_t [4];

  localparam logic OP_OVERRIDE = 1'b0;
  localparam logic OP_ADDITIVE = 1'b1;

  // ---------------------------------------------------------------- predictor
  class blend_scoreboard;
    out_data_t want_q[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    static function longint rnd_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    static function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    static function longint lane(logic [63:0] v, int i);
      return longint'($signed(v[16*i +: 16]));
    endfunction

    static function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function void unit(input quat_t v, output quat_t o);
      longint unsigned n, s, mag;
      longint q;
      n = 0;
      for (int i = 0; i < 4; i++) n += longint'(v[i] * v[i]);
      if (n == 0) begin
        o = '{0, 0, 0, Q_ONE};
        return;
      end
      s = root(n << 20);
      for (int i = 0; i < 4; i++) begin
        mag = (v[i] < 0) ? -v[i] : v[i];
        q = ((mag << 24) + s / 2) / s;
        o[i] = clip16(v[i] < 0 ? -q : q);
      end
    endfunction

    static function void nlerp(input quat_t l, input quat_t r, input longint w,
                               output quat_t o);
      longint dot, rr;
      quat_t t;
      dot = 0;
      for (int i = 0; i < 4; i++) dot += l[i] * r[i];
      for (int i = 0; i < 4; i++) begin
        rr = (dot < 0) ? -r[i] : r[i];
        t[i] = l[i] + rnd_shift((rr - l[i]) * w, 15);
      end
      unit(t, o);
    endfunction

    static function void qmul(input quat_t a, input quat_t b, output quat_t o);
      quat_t t;
      t[0] = rnd_shift(a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1], 14);
      t[1] = rnd_shift(a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0], 14);
      t[2] = rnd_shift(a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3], 14);
      t[3] = rnd_shift(a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2], 14);
      unit(t, o);
    endfunction

    // base + (to - from) * w; override passes base as from
    static function logic [VW-1:0] vmix(logic [VW-1:0] base, logic [VW-1:0] from,
                                        logic [VW-1:0] to, longint w);
      logic [VW-1:0] r;
      longint v;
      for (int i = 0; i < 3; i++) begin
        v = lane(base, i) + rnd_shift((lane(to, i) - lane(from, i)) * w, 15);
        r[16*i +: 16] = 16'(clip16(v));
      end
      return r;
    endfunction

    function void note_input(logic op, in_data_t d);
      longint w;
      quat_t bq, sq, nq, delta, part, res;
      out_data_t e;
      w = d.blend_weight;
      if (w > W_ONE) w = W_ONE;
      for (int i = 0; i < 4; i++) begin
        bq[i] = lane(d.base_rotation, i);
        sq[i] = lane(d.sample_rotation, i);
        nq[i] = lane(d.bind_rotation, i);
      end
      if (op == OP_ADDITIVE) begin
        for (int i = 0; i < 3; i++) nq[i] = -nq[i];
        qmul(sq, nq, delta);
        nlerp('{0, 0, 0, Q_ONE}, delta, w, part);
        qmul(bq, part, res);
        e.out_translation = vmix(d.base_translation, d.bind_translation,
                                 d.sample_translation, w);
        e.out_scale = vmix(d.base_scale, d.bind_scale, d.sample_scale, w);
      end else begin
        nlerp(bq, sq, w, res);
        e.out_translation = vmix(d.base_translation, d.base_translation,
                                 d.sample_translation, w);
        e.out_scale = vmix(d.base_scale, d.base_scale, d.sample_scale, w);
      end
      for (int i = 0; i < 4; i++) e.out_rotation[16*i +: 16] = 16'(res[i]);
      want_q.push_back(e);
    endfunction

    function void check_result(out_data_t got);
      out_data_t e;
      if (want_q.size() == 0) begin
        $error("unexpected result transfer %h", got);
        errors++;
        return;
      end
      e = want_q.pop_front();
      if (got.out_translation !== e.out_translation) begin
        $error("out_translation exp %h got %h", e.out_translation, got.out_translation);
        errors++;
      end
      if (got.out_rotation !== e.out_rotation) begin
        $error("out_rotation exp %h got %h", e.out_rotation, got.out_rotation);
        errors++;
      end
      if (got.out_scale !== e.out_scale) begin
        $error("out_scale exp %h got %h", e.out_scale, got.out_scale);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------- dut
  logic               clk, rst_n;
  logic               in_tvalid, in_tready, in_tuser;
  logic [IN_TDW-1:0]  in_tdata;
  logic               out_tvalid, out_tready;
  logic [OUT_TDW-1:0] out_tdata;

  pose_transform_blend dut (.*);

  blend_scoreboard sb = new();
  bit quiet;      // no idling on either side
  bit hold_req;   // receiver holds off for a long stretch

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** pose_transform_blend: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tuser, in_data_t'(in_tdata));
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_data_t'(out_tdata));
  end

  // receiver
  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold = 400;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = quiet || ($urandom_range(99) >= 12);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [QW-1:0] pick_quat();
    logic [QW-1:0] q;
    int unsigned k;
    k = $urandom_range(9);
    for (int i = 0; i < 4; i++) begin
      case (k)
        0:       q[16*i +: 16] = 16'h0000;
        1:       q[16*i +: 16] = ($urandom_range(2) == 0) ? 16'h8000 :
                                 ($urandom_range(1) == 0) ? 16'h7FFF : 16'h0000;
        2, 3:    q[16*i +: 16] = 16'($urandom);
        default: q[16*i +: 16] = 16'($signed($urandom_range(32768)) - 16384);
      endcase
    end
    return q;
  endfunction

  function automatic logic [VW-1:0] pick_vec();
    logic [VW-1:0] v;
    for (int i = 0; i < 3; i++)
      v[16*i +: 16] = ($urandom_range(3) == 0) ? 16'($urandom) :
                      16'($signed($urandom_range(4096)) - 2048);
    return v;
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'($urandom_range(65535, 32769));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic in_data_t pick_item();
    in_data_t d;
    d.base_translation   = pick_vec();
    d.base_rotation      = pick_quat();
    d.base_scale         = pick_vec();
    d.sample_translation = pick_vec();
    d.sample_rotation    = pick_quat();
    d.sample_scale       = pick_vec();
    d.bind_translation   = pick_vec();
    d.bind_rotation      = pick_quat();
    d.bind_scale         = pick_vec();
    d.blend_weight       = pick_weight();
    return d;
  endfunction

  task automatic send_bone(logic op, in_data_t d);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = d;
    do @(posedge clk); while (!in_tready);
    if (!quiet && $urandom_range(99) < 12) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      in_tuser  = 1'($urandom);
      in_tdata  = {$urandom, $urandom};
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  initial begin
    in_data_t d;
    logic [VW-1:0] v_hi, v_lo;
    logic [QW-1:0] ident, q_hi, q_lo;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    v_hi  = {3{16'h7FFF}};
    v_lo  = {3{16'h8000}};
    ident = {16'(Q_ONE), 48'h0};
    q_hi  = {4{16'h7FFF}};
    q_lo  = {4{16'h8000}};
    // directed: extremes, zero-length quaternions, weight above one,
    // negative and zero dot product, both operations
    for (int op = 0; op < 2; op++) begin
      d = '{16'd32768, v_hi, ident, v_hi, v_hi, q_hi, v_hi, v_lo, q_lo, v_lo};
      send_bone(op[0], d);
      d = '{16'd32768, v_lo, q_lo, v_lo, v_lo, q_lo, v_lo, v_hi, q_hi, v_hi};
      send_bone(op[0], d);
      d = '{16'd0, '0, '0, '0, v_hi, '0, v_lo, v_hi, '0, v_lo};
      send_bone(op[0], d);
      d = '{16'hFFFF, v_lo, q_hi, v_hi, v_lo, q_hi, v_hi, v_hi, ident, v_lo};
      send_bone(op[0], d);
      d = '{16'd16384, '0, ident, '0, v_hi, {16'(-Q_ONE), 48'h0}, v_hi, '0, ident, '0};
      send_bone(op[0], d);
      d = '{16'd16385, '0, {16'd0, 16'(Q_ONE), 32'h0}, '0, v_lo, ident, v_lo, '0, ident, '0};
      send_bone(op[0], d);
      d = '{16'd32769, v_hi, q_lo, v_lo, v_hi, q_hi, v_lo, v_lo, q_lo, v_hi};
      send_bone(op[0], d);
      d = '{16'd1, v_lo, '0, v_hi, v_lo, ident, v_hi, v_hi, {16'(-Q_ONE), 48'h0}, v_lo};
      send_bone(op[0], d);
    end

    for (int n = 0; n < 700; n++) begin
      quiet = (n >= 300 && n < 450);
      if (n == 150) hold_req = 1'b1;
      if (n == 500) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        while (sb.want_q.size() != 0) @(posedge clk);
      end
      send_bone(1'($urandom), pick_item());
    end
    @(negedge clk);
    in_tvalid = 1'b0;
    quiet = 1'b0;

    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** pose_transform_blend: PASSED **");
    end else begin
      $display("** pose_transform_blend: FAILED **");
    end
    $finish;
  end

endmodule

FILE: pose_transform_blend.f
hdl/ptb_pkg.sv
hdl/ptb_vblend.sv
hdl/ptb_qmul.sv
hdl/ptb_norm.sv
hdl/ptb_nlerp.sv
hdl/pose_transform_blend.sv
tb/tb_top.sv
